// ===== rtl/core/mmp3_pkg.sv =====
// ----------------------------------------------------------------------------
// mmp3_pkg
// Shared types and constants for the modular 3x3 matrix power unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mmp3_pkg;

    localparam int unsigned DIM     = 3;
    localparam int unsigned N_ENT   = DIM * DIM;
    localparam int unsigned IDX_W   = $clog2(N_ENT);
    localparam int unsigned RC_W    = $clog2(DIM);
    localparam int unsigned FIELD_W = 31;
    localparam int unsigned PROD_W  = 2 * FIELD_W;
    localparam int unsigned SUM_W   = PROD_W + 1;
    localparam int unsigned RCNT_W  = $clog2(SUM_W);

    localparam logic [FIELD_W-1:0] MOD_RESET = FIELD_W'(1000000007);

    typedef struct packed {
        logic [FIELD_W-1:0] base_00;
        logic [FIELD_W-1:0] base_01;
        logic [FIELD_W-1:0] base_02;
        logic [FIELD_W-1:0] base_10;
        logic [FIELD_W-1:0] base_11;
        logic [FIELD_W-1:0] base_12;
        logic [FIELD_W-1:0] base_20;
        logic [FIELD_W-1:0] base_21;
        logic [FIELD_W-1:0] base_22;
        logic [FIELD_W-1:0] exponent;
    } mmp3_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] power_00;
        logic [FIELD_W-1:0] power_01;
        logic [FIELD_W-1:0] power_02;
        logic [FIELD_W-1:0] power_10;
        logic [FIELD_W-1:0] power_11;
        logic [FIELD_W-1:0] power_12;
        logic [FIELD_W-1:0] power_20;
        logic [FIELD_W-1:0] power_21;
        logic [FIELD_W-1:0] power_22;
    } mmp3_out_t;

    // reducer status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mmp3_red_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_RED,
        ST_COPY,
        ST_OUT
    } mmp3_state_t;

    function automatic logic [IDX_W-1:0] idx(input logic [RC_W-1:0] r,
                                             input logic [RC_W-1:0] c);
        logic [IDX_W+RC_W:0] rw;
        logic [IDX_W+RC_W:0] cw;
        logic [IDX_W+RC_W:0] t;
        rw = (IDX_W+RC_W+1)'(r);
        cw = (IDX_W+RC_W+1)'(c);
        t  = rw * (IDX_W+RC_W+1)'(DIM) + cw;
        return t[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mmp3_modred.sv =====
// ----------------------------------------------------------------------------
// mmp3_modred
// Bit-serial restoring remainder: x mod m, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mmp3_modred (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mmp3_pkg::SUM_W-1:0]    x,
    input  wire logic [mmp3_pkg::FIELD_W-1:0]  m,
    output mmp3_pkg::mmp3_red_status_t         status,
    output logic      [mmp3_pkg::FIELD_W-1:0]  rem
);

    logic [mmp3_pkg::SUM_W-1:0]   x_reg;
    logic [mmp3_pkg::FIELD_W-1:0] r_reg;
    logic [mmp3_pkg::RCNT_W-1:0]  cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [mmp3_pkg::FIELD_W:0]   trial;
    logic [mmp3_pkg::FIELD_W:0]   r_next;

    // r < m, so 2r+1 fits one extra bit
    always_comb
    begin
        trial = {r_reg, x_reg[mmp3_pkg::SUM_W-1]};
        if (trial >= {1'b0, m})
        begin
            r_next = trial - {1'b0, m};
        end
        else
        begin
            r_next = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= mmp3_pkg::RCNT_W'(mmp3_pkg::SUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[mmp3_pkg::SUM_W-2:0], 1'b0};
            r_reg <= r_next[mmp3_pkg::FIELD_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign rem         = r_reg;

endmodule

`default_nettype wire

// ===== rtl/core/modular_matrix_power_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// modular_matrix_power_3x3_unit
// 3x3 matrix power modulo a configurable modulus, square-and-multiply.
// ----------------------------------------------------------------------------
// Sequence: each MAC is a multiply, an add, then the bit-serial reducer;
//   a matrix product is 27 MACs plus one copy step.
//   Total work is L + P matrix products, L = exponent bit length, P = its popcount;
//   exponent zero returns the identity.
// Throughput: one beat at a time; in_stall is high from accept until the result
//   beat is taken. Reset: control clears, modulus returns to 1000000007.
`default_nettype none

module modular_matrix_power_3x3_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [mmp3_pkg::FIELD_W-1:0]  cfg_write_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire mmp3_pkg::mmp3_in_t            in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output mmp3_pkg::mmp3_out_t                out_data
);

    localparam int unsigned FW = mmp3_pkg::FIELD_W;
    localparam int unsigned RW = mmp3_pkg::RC_W;

    mmp3_pkg::mmp3_state_t state_reg;
    mmp3_pkg::mmp3_state_t state_next;

    logic [FW-1:0] modulus_reg;
    logic [FW-1:0] eff_mod;

    // matrices: accumulator, running base, product scratch
    logic [FW-1:0] a_reg [mmp3_pkg::N_ENT];
    logic [FW-1:0] b_reg [mmp3_pkg::N_ENT];
    logic [FW-1:0] t_reg [mmp3_pkg::N_ENT];

    logic [FW-1:0]               exp_reg;
    logic [RW-1:0]               i_reg;
    logic [RW-1:0]               j_reg;
    logic [RW-1:0]               k_reg;
    logic                        sq_reg;     // 1: squaring base, 0: acc * base
    logic [FW-1:0]               part_reg;   // partial dot product, reduced
    logic [mmp3_pkg::PROD_W-1:0] prod_reg;

    logic [FW-1:0]              op_x;
    logic [FW-1:0]              op_y;
    logic                       red_start;
    logic [mmp3_pkg::SUM_W-1:0] red_x;
    logic [FW-1:0]              red_rem;
    mmp3_pkg::mmp3_red_status_t red_st;

    logic in_fire;
    logic out_fire;
    logic last_k;
    logic last_ent;

    assign eff_mod  = (modulus_reg == '0) ? FW'(1) : modulus_reg;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;
    assign last_k   = (k_reg == RW'(mmp3_pkg::DIM - 1));
    assign last_ent = (i_reg == RW'(mmp3_pkg::DIM - 1)) && (j_reg == RW'(mmp3_pkg::DIM - 1));

    // shared operand select for the single multiplier
    assign op_x  = sq_reg ? b_reg[mmp3_pkg::idx(i_reg, k_reg)]
                          : a_reg[mmp3_pkg::idx(i_reg, k_reg)];
    assign op_y  = b_reg[mmp3_pkg::idx(k_reg, j_reg)];
    assign red_x = mmp3_pkg::SUM_W'(prod_reg) + mmp3_pkg::SUM_W'(part_reg);

    mmp3_modred u_modred (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (red_start),
        .x      (red_x),
        .m      (eff_mod),
        .status (red_st),
        .rem    (red_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmp3_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (in_data.exponent == '0) ? mmp3_pkg::ST_OUT
                                                          : mmp3_pkg::ST_MUL;
                end
            end
            mmp3_pkg::ST_MUL:
            begin
                state_next = mmp3_pkg::ST_ACC;
            end
            mmp3_pkg::ST_ACC:
            begin
                state_next = mmp3_pkg::ST_RED;
            end
            mmp3_pkg::ST_RED:
            begin
                if (red_st.done)
                begin
                    state_next = (last_k && last_ent) ? mmp3_pkg::ST_COPY
                                                      : mmp3_pkg::ST_MUL;
                end
            end
            mmp3_pkg::ST_COPY:
            begin
                // after a square, stop once no set exponent bits remain
                if (sq_reg && (exp_reg[FW-1:1] == '0))
                begin
                    state_next = mmp3_pkg::ST_OUT;
                end
                else
                begin
                    state_next = mmp3_pkg::ST_MUL;
                end
            end
            mmp3_pkg::ST_OUT:
            begin
                if (out_fire)
                begin
                    state_next = mmp3_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmp3_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        red_start = 1'b0;
        unique case (state_reg)
            mmp3_pkg::ST_IDLE: in_stall  = 1'b0;
            mmp3_pkg::ST_ACC:  red_start = 1'b1;
            mmp3_pkg::ST_OUT:  out_valid = 1'b1;
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mmp3_pkg::ST_IDLE;
            modulus_reg <= mmp3_pkg::MOD_RESET;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            sq_reg      <= 1'b0;
            exp_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                modulus_reg <= cfg_write_data;
            end
            unique case (state_reg)
                mmp3_pkg::ST_IDLE:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                    k_reg <= '0;
                    if (in_fire)
                    begin
                        exp_reg <= in_data.exponent;
                        sq_reg  <= !in_data.exponent[0];
                    end
                end
                mmp3_pkg::ST_RED:
                begin
                    if (red_st.done)
                    begin
                        if (!last_k)
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                        else
                        begin
                            k_reg <= '0;
                            if (j_reg == RW'(mmp3_pkg::DIM - 1))
                            begin
                                j_reg <= '0;
                                i_reg <= last_ent ? '0 : i_reg + 1'b1;
                            end
                            else
                            begin
                                j_reg <= j_reg + 1'b1;
                            end
                        end
                    end
                end
                mmp3_pkg::ST_COPY:
                begin
                    if (sq_reg)
                    begin
                        exp_reg <= {1'b0, exp_reg[FW-1:1]};
                        sq_reg  <= !exp_reg[1];
                    end
                    else
                    begin
                        sq_reg <= 1'b1;
                    end
                end
                default:
                begin
                    sq_reg <= sq_reg;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mmp3_pkg::ST_IDLE:
            begin
                part_reg <= '0;
                if (in_fire)
                begin
                    b_reg[0] <= in_data.base_00;
                    b_reg[1] <= in_data.base_01;
                    b_reg[2] <= in_data.base_02;
                    b_reg[3] <= in_data.base_10;
                    b_reg[4] <= in_data.base_11;
                    b_reg[5] <= in_data.base_12;
                    b_reg[6] <= in_data.base_20;
                    b_reg[7] <= in_data.base_21;
                    b_reg[8] <= in_data.base_22;
                    for (int r = 0; r < mmp3_pkg::DIM; r++)
                    begin
                        for (int c = 0; c < mmp3_pkg::DIM; c++)
                        begin
                            a_reg[r * mmp3_pkg::DIM + c] <= (r == c) ? FW'(1) : '0;
                        end
                    end
                end
            end
            mmp3_pkg::ST_MUL:
            begin
                prod_reg <= op_x * op_y;
            end
            mmp3_pkg::ST_RED:
            begin
                if (red_st.done)
                begin
                    if (last_k)
                    begin
                        t_reg[mmp3_pkg::idx(i_reg, j_reg)] <= red_rem;
                        part_reg <= '0;
                    end
                    else
                    begin
                        part_reg <= red_rem;
                    end
                end
            end
            mmp3_pkg::ST_COPY:
            begin
                for (int n = 0; n < mmp3_pkg::N_ENT; n++)
                begin
                    if (sq_reg)
                    begin
                        b_reg[n] <= t_reg[n];
                    end
                    else
                    begin
                        a_reg[n] <= t_reg[n];
                    end
                end
            end
            default:
            begin
                part_reg <= part_reg;
            end
        endcase
    end

    assign out_data.power_00 = a_reg[0];
    assign out_data.power_01 = a_reg[1];
    assign out_data.power_02 = a_reg[2];
    assign out_data.power_10 = a_reg[3];
    assign out_data.power_11 = a_reg[4];
    assign out_data.power_12 = a_reg[5];
    assign out_data.power_20 = a_reg[6];
    assign out_data.power_21 = a_reg[7];
    assign out_data.power_22 = a_reg[8];

    // reducer finishes only while the sequencer waits on it
    a_done_in_red: assert property (@(posedge clk) disable iff (!rst_n)
        red_st.done |-> (state_reg == mmp3_pkg::ST_RED))
        else $error("reducer done outside reduce state");

    // reducer busy right after each start
    a_red_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmp3_pkg::ST_ACC) |=> red_st.busy)
        else $error("reducer not busy after start");

    // running partial sum always reduced
    a_part_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmp3_pkg::ST_MUL) |-> (part_reg < eff_mod))
        else $error("partial sum not below modulus");

    // accepted beat leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != mmp3_pkg::ST_IDLE))
        else $error("still idle after accept");

endmodule

`default_nettype wire
